// ===== rtl/hcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcs_pkg
// Shared types and constants for the hash comment stripper: the scanner
// mode, the character codes it reacts to and the queue entry format.
// ----------------------------------------------------------------------------
package hcs_pkg;

    // Default depth of the queue between scanner and emitter
    localparam int HCS_FIFO_DEPTH = 4;

    // Character codes
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Scanner mode
    typedef enum logic [2:0] {
        MODE_NORMAL      = 3'd0,
        MODE_BSL         = 3'd1,
        MODE_QUOTE       = 3'd2,
        MODE_QUOTE_BSL   = 3'd3,
        MODE_COMMENT     = 3'd4,
        MODE_COMMENT_BSL = 3'd5
    } t_hcs_mode;

    // One queued work item: a byte to send, preceded by a backslash if pair
    typedef struct packed {
        logic [7:0] data;
        logic       pair;
    } t_hcs_entry;

    // Queue status seen by its neighbors
    typedef struct packed {
        logic full;
        logic valid;
    } t_hcs_fifo_stat;

endpackage

// ===== rtl/hash_comment_stripper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_comment_stripper
// Removes '#' line comments from a byte stream, honoring quotes and
// backslash escapes.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the queue has room and sends the filtered
// text with last_of_run marking the final output byte of each input byte. A
// scanner classifies each byte; bytes that produce output go into a queue of
// FIFO_DEPTH entries and an emitter drains it into a registered output.
// Plain bytes leave at one per cycle while i_ready is high; an escaped pair
// (backslash plus the next byte) holds the output while both bytes are sent,
// and the input stalls whenever the queue is full. A byte passes the queue
// and then the output register on its way out. Comment bytes and comment
// line endings produce no output.
// ----------------------------------------------------------------------------
module hash_comment_stripper
    import hcs_pkg::*;
#(
    parameter int FIFO_DEPTH = HCS_FIFO_DEPTH
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    t_hcs_fifo_stat stat;
    t_hcs_entry     push_entry;
    t_hcs_entry     head_entry;
    logic           push;
    logic           pop;

    hcs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in_byte (i_in_byte),
        .i_stat    (stat),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    hcs_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_stat  (stat)
    );

    hcs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (head_entry),
        .i_stat        (stat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== rtl/hcs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcs_front
// Scanner: takes one text byte per cycle while the queue has room, tracks
// the six-state mode and pushes an entry for every byte that yields output.
// ----------------------------------------------------------------------------
module hcs_front
    import hcs_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_in_byte,
    input  t_hcs_fifo_stat i_stat,
    output logic           o_push,
    output t_hcs_entry     o_entry
);

    t_hcs_mode r_mode;
    t_hcs_mode n_mode;
    logic      emit;
    logic      pair;
    logic      accept;
    logic      is_eol;

    assign o_ready = !i_stat.full;
    assign accept  = i_valid && o_ready;
    assign is_eol  = (i_in_byte == CH_LF) || (i_in_byte == CH_CR);

    // Hold mode, advance on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
        end else if (accept) begin
            r_mode <= n_mode;
        end
    end

    // Classify the byte against the current mode
    always_comb begin
        n_mode = r_mode;
        emit   = 1'b0;
        pair   = 1'b0;
        unique case (r_mode)
            MODE_BSL: begin
                emit   = 1'b1;
                pair   = 1'b1;
                n_mode = MODE_NORMAL;
            end
            MODE_QUOTE: begin
                if (i_in_byte == CH_QUOTE) begin
                    emit   = 1'b1;
                    n_mode = MODE_NORMAL;
                end else if (i_in_byte == CH_BSL) begin
                    n_mode = MODE_QUOTE_BSL;
                end else begin
                    emit = 1'b1;
                end
            end
            MODE_QUOTE_BSL: begin
                emit   = 1'b1;
                pair   = 1'b1;
                n_mode = MODE_QUOTE;
            end
            MODE_COMMENT: begin
                if (is_eol) begin
                    n_mode = MODE_NORMAL;
                end else if (i_in_byte == CH_BSL) begin
                    n_mode = MODE_COMMENT_BSL;
                end
            end
            MODE_COMMENT_BSL: begin
                n_mode = is_eol ? MODE_COMMENT_BSL : MODE_COMMENT;
            end
            default: begin
                // Normal mode; unused codes behave the same
                if (i_in_byte == CH_HASH) begin
                    n_mode = MODE_COMMENT;
                end else if (i_in_byte == CH_BSL) begin
                    n_mode = MODE_BSL;
                end else if (i_in_byte == CH_QUOTE) begin
                    emit   = 1'b1;
                    n_mode = MODE_QUOTE;
                end else begin
                    emit   = 1'b1;
                    n_mode = MODE_NORMAL;
                end
            end
        endcase
    end

    assign o_push       = accept && emit;
    assign o_entry.data = i_in_byte;
    assign o_entry.pair = pair;

    // An unescaped hash outside quotes opens a comment and sends nothing
    a_hash_opens_comment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_mode == MODE_NORMAL && i_in_byte == CH_HASH)
        |=> (r_mode == MODE_COMMENT && !$past(o_push)))
        else $error("hash in normal mode did not open a comment");

endmodule

// ===== rtl/hcs_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcs_fifo
// Small register queue between scanner and emitter.
// ----------------------------------------------------------------------------
module hcs_fifo
    import hcs_pkg::*;
#(
    parameter int FIFO_DEPTH = HCS_FIFO_DEPTH
)
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  t_hcs_entry     i_entry,
    input  logic           i_pop,
    output t_hcs_entry     o_entry,
    output t_hcs_fifo_stat o_stat
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    t_hcs_entry       r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.valid = (r_count != '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && o_stat.valid;
    assign o_entry      = r_mem[r_rd_ptr];

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full))
        else $error("push into a full queue");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

endmodule

// ===== rtl/hcs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcs_back
// Emitter: pops queue entries into the output register, expanding an
// escaped entry into a backslash followed by the held byte.
// ----------------------------------------------------------------------------
module hcs_back
    import hcs_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_hcs_entry     i_entry,
    input  t_hcs_fifo_stat i_stat,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_last_of_run
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_pend;
    logic [7:0] r_pend_byte;
    logic       load;

    // Output slot free or being taken this cycle
    assign load  = !r_valid || i_ready;
    assign o_pop = load && !r_pend && i_stat.valid;

    // Control: output valid and pending second byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= i_stat.valid;
                r_pend  <= i_stat.valid && i_entry.pair;
            end
        end
    end

    // Payload: send backslash first for a pair, hold the byte for later
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_byte <= r_pend_byte;
                r_last <= 1'b1;
            end else if (i_entry.pair) begin
                r_byte      <= CH_BSL;
                r_last      <= 1'b0;
                r_pend_byte <= i_entry.data;
            end else begin
                r_byte <= i_entry.data;
                r_last <= 1'b1;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_byte;
    assign o_last_of_run = r_last;

    a_pend_has_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_valid && !r_last && r_byte == CH_BSL))
        else $error("pending byte without a leading backslash on the output");

    a_pend_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && i_ready) |=> (r_valid && r_last && !r_pend))
        else $error("second byte of an escaped pair not emitted next");

endmodule
